[hw/rtl/tsve_pkg.sv]
// Shared types, constants and helper functions for the tile splash veto evaluator.
// Depends on nothing; tsve_seq and the top level in hw/rtl import it.
package tsve_pkg;

    localparam int WORD_BITS   = 32;
    localparam int TABLE_WORDS = 130;
    localparam int ADDR_W      = 8;
    localparam int IDX_W       = $clog2(WORD_BITS);
    localparam int TOP_W       = 25;
    localparam int SIDE_W      = 26;

    localparam logic [ADDR_W-1:0] SPECIAL_0_ADDR = ADDR_W'(128);
    localparam logic [ADDR_W-1:0] SPECIAL_1_ADDR = ADDR_W'(129);
    localparam logic [ADDR_W-1:0] TABLE_LIMIT    = ADDR_W'(TABLE_WORDS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // y-side bit that marks the special tile
    localparam int SPECIAL_BIT = 25;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    // Kind of table-read step the sequencer is on
    typedef enum logic [3:0] {
        STEP_SP0,
        STEP_SP1,
        STEP_SW_FIRST,
        STEP_SW_LOOP,
        STEP_BW_FIRST0,
        STEP_BW_FIRST1,
        STEP_BW_LOOP0,
        STEP_BW_LOOP1,
        STEP_W1_LOOP
    } step_t;

    typedef struct packed {
        logic  none;
        step_t step;
        logic  sw_w1;
    } disp_t;

    typedef struct packed {
        logic valid;
        logic veto;
    } res_t;

    // Index counts from the MSB; an all-zero word gives the last index.
    function automatic logic [IDX_W-1:0] lead_index(input logic [WORD_BITS-1:0] w);
        logic [IDX_W-1:0] n;
        n = IDX_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 2; i >= 0; i--)
        begin
            if (w[WORD_BITS-1-i])
            begin
                n = IDX_W'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [WORD_BITS-1:0] index_bit(input logic [IDX_W-1:0] n);
        return {1'b1, {(WORD_BITS-1){1'b0}}} >> n;
    endfunction

    function automatic logic [WORD_BITS-1:0] pack_w0(input logic [TOP_W-1:0]  top,
                                                     input logic [SIDE_W-1:0] y);
        return {y[24:18], top};
    endfunction

    function automatic logic [WORD_BITS-1:0] pack_w1(input logic [SIDE_W-1:0] x,
                                                     input logic [SIDE_W-1:0] y);
        return {y[17:16], y[9:0], x[25:16], x[9:0]};
    endfunction

    // Which walk follows once the special-tile check is over
    function automatic disp_t dispatch(input logic [WORD_BITS-1:0] w0,
                                       input logic [WORD_BITS-1:0] w1);
        disp_t d;
        d.none  = 1'b0;
        d.step  = STEP_SW_FIRST;
        d.sw_w1 = 1'b0;
        if (w0 != '0 && w1 != '0)
        begin
            d.step = STEP_BW_FIRST0;
        end
        else if (w0 != '0)
        begin
            d.step = STEP_SW_FIRST;
        end
        else if (w1 != '0)
        begin
            d.sw_w1 = 1'b1;
        end
        else
        begin
            d.none = 1'b1;
        end
        return d;
    endfunction

endpackage

[hw/rtl/tsve_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tsve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 130
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/tsve_seq.sv]
// Sequencer of the splash veto: takes input transfers, issues table writes and
// walks the struck tiles one table read at a time. Depends on tsve_pkg.
module tsve_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [tsve_pkg::ADDR_W-1:0]     table_addr,
    input  logic [tsve_pkg::WORD_BITS-1:0]  table_data,
    input  logic [tsve_pkg::TOP_W-1:0]      top_hits,
    input  logic [tsve_pkg::SIDE_W-1:0]     x_side_hits,
    input  logic [tsve_pkg::SIDE_W-1:0]     y_side_hits,
    output tsve_pkg::res_t                  res,
    input  logic                            res_ready,
    output logic                            ram_we,
    output logic [tsve_pkg::ADDR_W-1:0]     ram_waddr,
    output logic [tsve_pkg::WORD_BITS-1:0]  ram_wdata,
    output logic                            ram_re,
    output logic [tsve_pkg::ADDR_W-1:0]     ram_raddr,
    input  logic [tsve_pkg::WORD_BITS-1:0]  ram_rdata
);

    import tsve_pkg::*;

    state_t                state_reg, state_next;
    step_t                 step_reg;
    logic [WORD_BITS-1:0]  w0_reg, w1_reg;
    logic [IDX_W-1:0]      n_reg;
    logic                  sw_w1_reg;
    logic                  veto_reg;

    logic                  acc;
    logic [WORD_BITS-1:0]  acc_w0, acc_w1;
    disp_t                 acc_disp;
    logic                  acc_special;

    logic [WORD_BITS-1:0]  rd_src;
    logic [IDX_W-1:0]      rd_n;
    logic [ADDR_W-1:0]     rd_addr;

    logic [WORD_BITS-1:0]  bn, hits, h, far, h2;
    disp_t                 ev_disp;
    logic                  ev_fin, ev_veto, ev_sw_w1;
    step_t                 ev_step;
    logic [WORD_BITS-1:0]  ev_w0, ev_w1;

    assign acc         = in_valid && (state_reg == ST_IDLE);
    assign acc_w0      = pack_w0(top_hits, y_side_hits);
    assign acc_w1      = pack_w1(x_side_hits, y_side_hits);
    assign acc_disp    = dispatch(acc_w0, acc_w1);
    assign acc_special = y_side_hits[SPECIAL_BIT];

    // Read issue: pick the tile index and the table word
    always_comb
    begin
        case (step_reg)
            STEP_SW_FIRST, STEP_SW_LOOP: rd_src = sw_w1_reg ? w1_reg : w0_reg;
            STEP_W1_LOOP:                rd_src = w1_reg;
            default:                     rd_src = w0_reg;
        endcase

        if (step_reg == STEP_BW_FIRST1 || step_reg == STEP_BW_LOOP1)
        begin
            rd_n = n_reg;
        end
        else
        begin
            rd_n = lead_index(rd_src);
        end

        case (step_reg)
            STEP_SP0:       rd_addr = SPECIAL_0_ADDR;
            STEP_SP1:       rd_addr = SPECIAL_1_ADDR;
            STEP_SW_FIRST,
            STEP_SW_LOOP:   rd_addr = sw_w1_reg ? {2'b01, rd_n, 1'b1} : {2'b00, rd_n, 1'b0};
            STEP_BW_FIRST0,
            STEP_BW_LOOP0:  rd_addr = {2'b00, rd_n, 1'b0};
            STEP_BW_FIRST1,
            STEP_BW_LOOP1:  rd_addr = {2'b00, rd_n, 1'b1};
            STEP_W1_LOOP:   rd_addr = {2'b01, rd_n, 1'b1};
            default:        rd_addr = SPECIAL_0_ADDR;
        endcase
    end

    // Step evaluation on the returned table word
    assign bn      = index_bit(n_reg);
    assign hits    = sw_w1_reg ? w1_reg : w0_reg;
    assign ev_disp = dispatch(w0_reg, w1_reg);

    always_comb
    begin
        ev_fin   = 1'b0;
        ev_veto  = 1'b0;
        ev_step  = step_reg;
        ev_w0    = w0_reg;
        ev_w1    = w1_reg;
        ev_sw_w1 = sw_w1_reg;
        h        = '0;
        far      = '0;
        h2       = '0;

        case (step_reg)
            STEP_SP0:
            begin
                far = w0_reg & ram_rdata;
                h2  = w1_reg | (w0_reg & ~index_bit(lead_index(far)));
                if (far != '0 && h2 != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = 1'b1;
                end
                else
                begin
                    ev_step = STEP_SP1;
                end
            end
            STEP_SP1:
            begin
                far = w1_reg & ram_rdata;
                h2  = w0_reg | (w1_reg & ~index_bit(lead_index(far)));
                if (far != '0 && h2 != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = 1'b1;
                end
                else if (ev_disp.none)
                begin
                    ev_fin = 1'b1;
                end
                else
                begin
                    ev_step  = ev_disp.step;
                    ev_sw_w1 = ev_disp.sw_w1;
                end
            end
            STEP_SW_FIRST:
            begin
                h   = hits & ~bn;
                far = h & ram_rdata;
                h2  = h & ~index_bit(lead_index(far));
                if (far != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = (h2 != '0);
                end
                else if (h == '0)
                begin
                    ev_fin = 1'b1;
                end
                else
                begin
                    ev_step = STEP_SW_LOOP;
                end
                if (sw_w1_reg)
                begin
                    ev_w1 = h;
                end
                else
                begin
                    ev_w0 = h;
                end
            end
            STEP_SW_LOOP:
            begin
                h = hits & ~bn;
                if ((h & ram_rdata) != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = 1'b1;
                end
                else if (h == '0)
                begin
                    ev_fin = 1'b1;
                end
                if (sw_w1_reg)
                begin
                    ev_w1 = h;
                end
                else
                begin
                    ev_w0 = h;
                end
            end
            STEP_BW_FIRST0:
            begin
                h = w0_reg & ~bn;
                if ((h & ram_rdata) != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = 1'b1;
                end
                else
                begin
                    ev_w0   = h;
                    ev_step = STEP_BW_FIRST1;
                end
            end
            STEP_BW_FIRST1:
            begin
                far = w1_reg & ram_rdata;
                h2  = w1_reg & ~index_bit(lead_index(far));
                if (far != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = (w0_reg != '0) || (h2 != '0);
                end
                else if (w0_reg != '0)
                begin
                    ev_step = STEP_BW_LOOP0;
                end
                else if (w1_reg != '0)
                begin
                    ev_step = STEP_W1_LOOP;
                end
                else
                begin
                    ev_fin = 1'b1;
                end
            end
            STEP_BW_LOOP0:
            begin
                // mask is checked before the tile's own bit is cleared
                if ((w0_reg & ram_rdata) != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = 1'b1;
                end
                else
                begin
                    ev_w0   = w0_reg & ~bn;
                    ev_step = STEP_BW_LOOP1;
                end
            end
            STEP_BW_LOOP1:
            begin
                if ((w1_reg & ram_rdata) != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = 1'b1;
                end
                else if (w0_reg != '0)
                begin
                    ev_step = STEP_BW_LOOP0;
                end
                else if (w1_reg != '0)
                begin
                    ev_step = STEP_W1_LOOP;
                end
                else
                begin
                    ev_fin = 1'b1;
                end
            end
            STEP_W1_LOOP:
            begin
                h = w1_reg & ~bn;
                if ((h & ram_rdata) != '0)
                begin
                    ev_fin  = 1'b1;
                    ev_veto = 1'b1;
                end
                else if (h == '0)
                begin
                    ev_fin = 1'b1;
                end
                ev_w1 = h;
            end
            default:
            begin
                ev_fin = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_WRITE)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (acc_special || !acc_disp.none)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ev_fin ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        res.valid = (state_reg == ST_DONE);
        res.veto  = veto_reg;
        ram_we    = acc && (opcode == OP_WRITE) && (table_addr < TABLE_LIMIT);
        ram_waddr = table_addr;
        ram_wdata = table_data;
        ram_re    = (state_reg == ST_READ);
        ram_raddr = rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            veto_reg  <= 1'b0;
            w0_reg    <= acc_w0;
            w1_reg    <= acc_w1;
            step_reg  <= acc_special ? STEP_SP0 : acc_disp.step;
            sw_w1_reg <= acc_disp.sw_w1;
        end
        else if (state_reg == ST_READ)
        begin
            n_reg <= rd_n;
        end
        else if (state_reg == ST_EVAL)
        begin
            veto_reg  <= ev_veto;
            w0_reg    <= ev_w0;
            w1_reg    <= ev_w1;
            step_reg  <= ev_step;
            sw_w1_reg <= ev_sw_w1;
        end
    end

endmodule

[hw/rtl/tile_splash_veto_eval_unit.sv]
// Top level of the tile splash veto evaluator: sequencer, neighbour table RAM and
// output register. Depends on tsve_pkg, tsve_ram and tsve_seq.
//
// Input channel (in_valid / in_stall): one item per transfer. OP_WRITE stores
// table_data at table_addr (addresses above 129 are dropped) and gives veto 0;
// OP_EVAL packs the top, X-side and Y-side hit masks and decides the veto.
// Output channel (out_valid / out_stall): one veto per input item, in order.
// An evaluation makes its table reads one at a time: one per special-tile
// word when the special bit is set, then one per struck tile (two per top/Y-upper
// tile while both packed words hold hits), stopping once the veto is decided.
// Each read is an address, then registered RAM data, as the
// single RAM read port allows. One item is in work at a time, so a new
// transfer is taken only once the last result has left the sequencer.
// Reset clears the control state only; table words are undefined until
// written, so every word an evaluation reaches must have been written.
// While out_stall holds, the output transfer and its veto stay put; one
// further finished result waits in the sequencer, then input stalls.
module tile_splash_veto_eval_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [tsve_pkg::ADDR_W-1:0]     table_addr,
    input  logic [tsve_pkg::WORD_BITS-1:0]  table_data,
    input  logic [tsve_pkg::TOP_W-1:0]      top_hits,
    input  logic [tsve_pkg::SIDE_W-1:0]     x_side_hits,
    input  logic [tsve_pkg::SIDE_W-1:0]     y_side_hits,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            veto
);

    import tsve_pkg::*;

    res_t                  res;
    logic                  res_ready;
    logic                  ram_we, ram_re;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;
    logic                  out_valid_reg;
    logic                  veto_reg;

    tsve_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .table_addr  (table_addr),
        .table_data  (table_data),
        .top_hits    (top_hits),
        .x_side_hits (x_side_hits),
        .y_side_hits (y_side_hits),
        .res         (res),
        .res_ready   (res_ready),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // Far-neighbour table: word-0 masks, word-1 masks, two special-tile masks
    tsve_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_WORDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register takes a result when empty or when its transfer completes
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            veto_reg <= res.veto;
        end
    end

    assign out_valid = out_valid_reg;
    assign veto      = veto_reg;

endmodule

[tb/sv/tb_tile_splash_veto_eval_unit.sv]
// Self-checking testbench for tile_splash_veto_eval_unit: table writes and splash
// evaluations, checked against an in-bench predictor of the veto decision.
// Depends on tsve_pkg and the RTL under hw/rtl; reads no files.
module tb_tile_splash_veto_eval_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tsve_pkg::*;

    // Longest stretch with no transfer on either channel before giving up.
    // Worst case is the forced receiver hold plus one long evaluation.
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AT      = 500;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned TOTAL_ITEMS  = 1250;
    localparam int unsigned PRINT_CAP    = 40;
    localparam int          W1_TABLE     = 64;

    typedef struct {
        logic                  op;
        logic [ADDR_W-1:0]     addr;
        logic [WORD_BITS-1:0]  data;
        logic [TOP_W-1:0]      top;
        logic [SIDE_W-1:0]     x;
        logic [SIDE_W-1:0]     y;
    } splash_cmd_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_HEAVY
    } rx_mode_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  opcode      = OP_WRITE;
    logic [ADDR_W-1:0]     table_addr  = '0;
    logic [WORD_BITS-1:0]  table_data  = '0;
    logic [TOP_W-1:0]      top_hits    = '0;
    logic [SIDE_W-1:0]     x_side_hits = '0;
    logic [SIDE_W-1:0]     y_side_hits = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  veto;

    // Bench copy of the far-neighbour table, updated in transfer order
    logic [WORD_BITS-1:0]  far_table [0:TABLE_WORDS-1];

    splash_cmd_t           cmd_backlog [$];
    bit                    veto_due    [$];
    splash_cmd_t           on_bus;

    int unsigned n_queued;
    int unsigned n_accepted;
    int unsigned n_results;
    int unsigned n_errors;
    int unsigned n_writes;
    int unsigned n_dropped_writes;
    int unsigned n_evals;
    int unsigned n_veto_high;
    int unsigned hold_left;
    bit          held_off;

    tile_splash_veto_eval_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .table_addr  (table_addr),
        .table_data  (table_data),
        .top_hits    (top_hits),
        .x_side_hits (x_side_hits),
        .y_side_hits (y_side_hits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .veto        (veto)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Veto predictor. Bit index n counts from the MSB of a packed word.
    // ------------------------------------------------------------------
    function automatic logic [4:0] msb_index(input logic [WORD_BITS-1:0] w);
        int n;
        n = 0;
        while (n < WORD_BITS - 1 && w[WORD_BITS-1-n] == 1'b0)
        begin
            n++;
        end
        return n[4:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] msb_bit(input logic [4:0] n);
        return 32'h8000_0000 >> n;
    endfunction

    function automatic logic [WORD_BITS-1:0] far_of(input int base, input logic [4:0] n,
                                                    input bit sel);
        return far_table[base + 2 * int'(n) + int'(sel)];
    endfunction

    // One packed word on its own, against its own masks
    function automatic bit lone_word_veto(input logic [WORD_BITS-1:0] hits, input int base,
                                          input bit sel);
        logic [4:0]           n;
        logic [WORD_BITS-1:0] far;
        logic [WORD_BITS-1:0] msk;
        n    = msb_index(hits);
        hits = hits & ~msb_bit(n);
        far  = hits & far_of(base, n, sel);
        if (far != '0)
        begin
            n    = msb_index(far);
            hits = hits & ~msb_bit(n);
            if (hits != '0)
            begin
                return 1'b1;
            end
        end
        while (hits != '0)
        begin
            n    = msb_index(hits);
            msk  = far_of(base, n, sel);
            hits = hits & ~msb_bit(n);
            if ((hits & msk) != '0)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit paired_words_veto(input logic [WORD_BITS-1:0] w0,
                                             input logic [WORD_BITS-1:0] w1);
        logic [4:0]           n;
        logic [WORD_BITS-1:0] far;
        logic [WORD_BITS-1:0] msk;
        n  = msb_index(w0);
        w0 = w0 & ~msb_bit(n);
        if ((w0 & far_of(0, n, 1'b0)) != '0)
        begin
            return 1'b1;
        end
        far = w1 & far_of(0, n, 1'b1);
        if (far != '0)
        begin
            if (w0 != '0)
            begin
                return 1'b1;
            end
            n = msb_index(far);
            return (w1 & ~msb_bit(n)) != '0;
        end
        while (w0 != '0)
        begin
            n = msb_index(w0);
            if ((w0 & far_of(0, n, 1'b0)) != '0)
            begin
                return 1'b1;
            end
            w0 = w0 & ~msb_bit(n);
            if ((w1 & far_of(0, n, 1'b1)) != '0)
            begin
                return 1'b1;
            end
        end
        while (w1 != '0)
        begin
            n   = msb_index(w1);
            msk = far_of(W1_TABLE, n, 1'b1);
            w1  = w1 & ~msb_bit(n);
            if ((w1 & msk) != '0)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit splash_veto(input logic [TOP_W-1:0] top, input logic [SIDE_W-1:0] x,
                                       input logic [SIDE_W-1:0] y);
        logic [WORD_BITS-1:0] xx;
        logic [WORD_BITS-1:0] yy;
        logic [WORD_BITS-1:0] w0;
        logic [WORD_BITS-1:0] w1;
        logic [WORD_BITS-1:0] far;
        logic [4:0]           n;
        xx = 32'(x);
        yy = 32'(y);
        // top tiles fill bits 0-24 of word 0, upper Y tiles the rest
        w0 = 32'(top) | (((yy >> 18) & 32'h7F) << 25);
        w1 = (xx & 32'h3FF) | (((xx >> 16) & 32'h3FF) << 10)
           | ((yy & 32'h3FF) << 20) | (((yy >> 16) & 32'h3) << 30);
        if (y[SPECIAL_BIT])
        begin
            far = w0 & far_table[SPECIAL_0_ADDR];
            if (far != '0)
            begin
                n = msb_index(far);
                if ((w1 | (w0 & ~msb_bit(n))) != '0)
                begin
                    return 1'b1;
                end
            end
            far = w1 & far_table[SPECIAL_1_ADDR];
            if (far != '0)
            begin
                n = msb_index(far);
                if ((w0 | (w1 & ~msb_bit(n))) != '0)
                begin
                    return 1'b1;
                end
            end
        end
        if (w0 != '0)
        begin
            return (w1 != '0) ? paired_words_veto(w0, w1) : lone_word_veto(w0, 0, 1'b0);
        end
        if (w1 != '0)
        begin
            return lone_word_veto(w1, W1_TABLE, 1'b1);
        end
        return 1'b0;
    endfunction

    // Applies one accepted transfer to the bench table and queues its veto
    function automatic void predict_transfer(input splash_cmd_t c);
        if (c.op == OP_WRITE)
        begin
            if (c.addr < TABLE_LIMIT)
            begin
                far_table[c.addr] = c.data;
            end
            else
            begin
                n_dropped_writes++;
            end
            n_writes++;
            veto_due.push_back(1'b0);
        end
        else
        begin
            n_evals++;
            veto_due.push_back(splash_veto(c.top, c.x, c.y));
        end
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building. Fields that the opcode ignores carry noise.
    // ------------------------------------------------------------------
    function automatic logic [WORD_BITS-1:0] neighbour_word();
        logic [WORD_BITS-1:0] w;
        int                   k;
        w = '0;
        case ($urandom_range(0, 9))
            0, 1:    w = '0;
            2, 3:    w = $urandom;
            4:       w = '1;
            default:
            begin
                k = $urandom_range(1, 3);
                repeat (k) w[$urandom_range(0, WORD_BITS - 1)] = 1'b1;
            end
        endcase
        return w;
    endfunction

    task automatic queue_write(input logic [ADDR_W-1:0] addr, input logic [WORD_BITS-1:0] data);
        splash_cmd_t c;
        c.op   = OP_WRITE;
        c.addr = addr;
        c.data = data;
        c.top  = TOP_W'($urandom);
        c.x    = SIDE_W'($urandom);
        c.y    = SIDE_W'($urandom);
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    task automatic queue_eval(input logic [TOP_W-1:0] top, input logic [SIDE_W-1:0] x,
                              input logic [SIDE_W-1:0] y);
        splash_cmd_t c;
        c.op   = OP_EVAL;
        c.addr = ADDR_W'($urandom);
        c.data = $urandom;
        c.top  = top;
        c.x    = x;
        c.y    = y;
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    // Marks one struck tile, p naming a bit of the two packed words (0-63)
    task automatic strike(input int p, inout logic [TOP_W-1:0] top,
                          inout logic [SIDE_W-1:0] x, inout logic [SIDE_W-1:0] y);
        int q;
        q = p - WORD_BITS;
        if (p < TOP_W)
            top[p] = 1'b1;
        else if (p < WORD_BITS)
            y[p - 7] = 1'b1;
        else if (q < 10)
            x[q] = 1'b1;
        else if (q < 20)
            x[q + 6] = 1'b1;
        else if (q < 30)
            y[q - 20] = 1'b1;
        else
            y[q - 14] = 1'b1;
    endtask

    task automatic queue_random_eval();
        logic [TOP_W-1:0]  top;
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] y;
        int                hits;
        int                r;
        top = '0;
        x   = '0;
        y   = '0;
        r   = $urandom_range(0, 9);
        if (r == 9)
        begin
            top = TOP_W'($urandom);
            x   = SIDE_W'($urandom);
            y   = SIDE_W'($urandom);
        end
        else
        begin
            hits = (r == 0) ? 0 : (r <= 6) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            repeat (hits) strike($urandom_range(0, 2 * WORD_BITS - 1), top, x, y);
            y[SPECIAL_BIT] = ($urandom_range(0, 3) == 0);
            // unused side bits now and then
            if ($urandom_range(0, 3) == 0)
            begin
                x[15:10] = 6'($urandom);
                y[15:10] = 6'($urandom);
            end
        end
        queue_eval(top, x, y);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps; a stretch with no gaps.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        int unsigned gap_left;
        int unsigned burst_left;
        bit          took;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end
        else
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                predict_transfer(on_bus);
                n_accepted++;
            end
            if (in_valid && !took)
            begin
                // stalled: payload holds
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (cmd_backlog.size() > 0)
            begin
                on_bus = cmd_backlog.pop_front();
                in_valid    <= 1'b1;
                opcode      <= on_bus.op;
                table_addr  <= on_bus.addr;
                table_data  <= on_bus.data;
                top_hits    <= on_bus.top;
                x_side_hits <= on_bus.x;
                y_side_hits <= on_bus.y;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if (n_accepted >= 200 && n_accepted < 350)
                        gap_left = 0;
                    else if ($urandom_range(0, 4) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(10, 25);
                    else
                        gap_left = $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern. Once, a long hold-off fills the block up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : stall_blk
        rx_mode_t    rx_mode;
        int unsigned rx_left;
        int unsigned rx_phase;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_mode   = RX_FREE;
            rx_left   = 0;
            rx_phase  = 0;
            hold_left = 0;
            held_off  = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!held_off && n_results >= HOLD_AT)
        begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 128);
            end
            rx_left--;
            rx_phase++;
            if (n_accepted >= 200 && n_accepted < 350)
                rx_mode = RX_FREE;
            case (rx_mode)
                RX_FREE:    out_stall <= 1'b0;
                RX_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
                RX_PATTERN: out_stall <= ((rx_phase % 5) >= 3);
                default:    out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each output transfer against the oldest expected veto.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_blk
        bit want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (veto_due.size() == 0)
            begin
                report_mismatch($sformatf("veto %b with nothing outstanding", veto));
            end
            else
            begin
                want = veto_due.pop_front();
                if (veto !== want)
                begin
                    report_mismatch($sformatf("result %0d: veto %b, expected %b",
                                              n_results, veto, want));
                end
            end
            if (veto === 1'b1)
            begin
                n_veto_high++;
            end
        end
    end

    // Watchdog: ends the run after too long without any transfer
    always @(posedge clk)
    begin : dog_blk
        int unsigned quiet;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet == IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transfer, %0d results owed",
                         IDLE_LIMIT, veto_due.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stim_blk
        int r;
        int base;
        // Every table word is written up front, so no evaluation can ever
        // touch a word the block has not stored.
        for (int a = 0; a < TABLE_WORDS; a++)
        begin
            queue_write(ADDR_W'(a), neighbour_word());
        end

        // Directed part: extremes, each walk, the special tile, dropped writes
        queue_eval('0, '0, '0);                                 // no hits at all
        queue_eval('0, 26'h000_FC00, 26'h000_FC00);             // unused side bits only
        queue_eval('0, '0, 26'h200_0000);                       // special tile alone
        queue_eval('1, '1, '1);                                 // everything struck
        queue_eval(25'h000_0001, '0, '0);                       // one top tile
        queue_eval('0, '0, 26'h100_0000);                       // word 0 MSB alone
        queue_eval('0, 26'h000_0001, '0);                       // one word-1 tile
        queue_eval('0, 26'h200_0000, 26'h002_0000);             // two word-1 tiles, one at the MSB
        queue_eval(25'h100_0001, '0, 26'h004_0000);             // three in word 0
        queue_eval('0, 26'h001_0201, 26'h000_0200);             // four in word 1
        queue_eval(25'h000_8000, 26'h000_0010, '0);             // one in each word
        queue_eval(25'h180_0000, 26'h000_0300, 26'h001_0001);   // several in both
        queue_write(SPECIAL_0_ADDR, '1);
        queue_write(SPECIAL_1_ADDR, '0);
        queue_eval(25'h000_0003, '0, 26'h200_0000);             // special hit on word 0
        queue_write(ADDR_W'(0), '0);
        queue_write(TABLE_LIMIT, '1);                           // just past the table
        queue_write('1, $urandom);                              // top address
        queue_write(SPECIAL_0_ADDR, '0);
        queue_write(SPECIAL_1_ADDR, '1);
        queue_eval('0, 26'h000_0C00, 26'h200_0000);             // special tile, unused x bits only
        queue_eval('1, '0, '0);
        queue_eval('0, '1, '0);
        queue_eval('0, '0, 26'h1FF_FFFF);

        // Random part: mostly evaluations, with table rewrites mixed in so
        // the masks drift between sparse, empty and dense regimes.
        while (n_queued < TOTAL_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                queue_write(ADDR_W'($urandom_range(0, TABLE_WORDS - 1)), neighbour_word());
            end
            else if (r < 8)
            begin
                queue_write(ADDR_W'($urandom_range(TABLE_WORDS, 255)), $urandom);
            end
            else if (r < 10)
            begin
                base = $urandom_range(0, TABLE_WORDS - 16);
                for (int a = base; a < base + 16; a++)
                begin
                    queue_write(ADDR_W'(a), neighbour_word());
                end
            end
            else
            begin
                queue_random_eval();
            end
        end

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_queued || veto_due.size() != 0)
        begin
            @(posedge clk);
        end
        // Anything late or spurious shows up in this window
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d table writes (%0d dropped past the table) and %0d evaluations;",
                 n_writes, n_dropped_writes, n_evals);
        $display("%0d vetoes raised, receiver held off once for %0d cycles, %0d mismatches.",
                 n_veto_high, HOLD_CYCLES, n_errors);
        if (n_errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
